// ----- hdl/bsc_pkg.sv -----
// ----------------------------------------------------------------------------
// bsc_pkg: shared constants and types for barometric compensation
// Register indexes, divider depth and the restoring division step.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int DIV_STAGES = 32;

  localparam logic [2:0] REG_COEF_A       = 3'd0;
  localparam logic [2:0] REG_COEF_B       = 3'd1;
  localparam logic [2:0] REG_COEF_C       = 3'd2;
  localparam logic [2:0] REG_OVERSAMPLING = 3'd3;

  // partial remainder and numerator/quotient shift word
  typedef struct packed {
    logic [31:0] r;
    logic [31:0] n;
  } div_st_t;

  // one restoring step: shift in next numerator bit, trial subtract
  function automatic div_st_t div_step(input div_st_t s, input logic [31:0] d);
    logic [32:0] t;
    div_st_t     o;
    t = {s.r, s.n[31]};
    if (t >= {1'b0, d}) begin
      t   = t - {1'b0, d};
      o.n = {s.n[30:0], 1'b1};
    end else begin
      o.n = {s.n[30:0], 1'b0};
    end
    o.r = t[31:0];
    return o;
  endfunction

endpackage

// ----- hdl/bsc_div.sv -----
// ----------------------------------------------------------------------------
// bsc_div: pipelined unsigned 32/32 divider
// One quotient bit per stage, valid bit per stage, global advance enable.
// ----------------------------------------------------------------------------
module bsc_div
  import bsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        out_valid,
  output logic [31:0] quo
);

  div_st_t     st [DIV_STAGES];
  logic [31:0] dd [DIV_STAGES];
  logic        vv [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          vv[k] <= 1'b0;
        end else if (en) begin
          vv[k] <= in_valid;
        end
        if (en) begin
          st[k] <= div_step('{r: 32'd0, n: num}, den);
          dd[k] <= den;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (rst) begin
          vv[k] <= 1'b0;
        end else if (en) begin
          vv[k] <= vv[k-1];
        end
        if (en) begin
          st[k] <= div_step(st[k-1], dd[k-1]);
          dd[k] <= dd[k-1];
        end
      end
    end
  end

  assign out_valid = vv[DIV_STAGES-1];
  assign quo       = st[DIV_STAGES-1].n;

endmodule

// ----- hdl/barometric_sensor_compensation_core.sv -----
// ----------------------------------------------------------------------------
// barometric_sensor_compensation_core: temperature and pressure compensation
// Pipeline: 2 + 32 divider + 5 + 32 divider + 3 register stages from input
//   transaction to result. Throughput: one transaction per cycle while the output
//   is not stalled, set by the fully pipelined one-bit-per-stage dividers.
// Reset: synchronous; clears all valid bits, coefficients to 0, oversampling 3.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation_core
  import bsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        raw_temperature,
  input  logic [23:0]        raw_pressure_bytes,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [27:0] temperature_tenths,
  output logic signed [31:0] pressure_pa,
  output logic [1:0]         divide_error
);

  function automatic logic [31:0] asr(input logic [31:0] v, input int n);
    return 32'($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] sx(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // ---------------- configuration ----------------
  logic [63:0] coef_a, coef_b;
  logic [31:0] coef_c;
  logic [1:0]  oss;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a <= '0;
      coef_b <= '0;
      coef_c <= '0;
      oss    <= 2'd3;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COEF_A:       coef_a <= cfg_data;
        REG_COEF_B:       coef_b <= cfg_data;
        REG_COEF_C:       coef_c <= cfg_data[31:0];
        REG_OVERSAMPLING: oss    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = sx(coef_a[15:0]);
  assign ac2 = sx(coef_a[31:16]);
  assign ac3 = sx(coef_a[47:32]);
  assign ac4 = {16'd0, coef_a[63:48]};
  assign ac5 = {16'd0, coef_b[15:0]};
  assign ac6 = {16'd0, coef_b[31:16]};
  assign b1  = sx(coef_b[47:32]);
  assign b2  = sx(coef_b[63:48]);
  assign mc  = sx(coef_c[15:0]);
  assign md  = sx(coef_c[31:16]);

  // Whole pipeline advances together; output stage is the skid point.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // ---------------- stage 1: align pressure, first product ----------------
  logic        v1;
  logic [31:0] p1;
  logic [23:0] up1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
    if (en) begin
      p1  <= ({16'd0, raw_temperature} - ac6) * ac5;
      up1 <= raw_pressure_bytes >> (4'd8 - {2'b00, oss});
    end
  end

  // ---------------- stage 2: temperature divider operands ----------------
  logic        v2, neg2, dz2;
  logic [31:0] x1_2, an2, ad2;
  logic [23:0] up2;
  logic [31:0] x1_c, den_c, num_c;
  assign x1_c  = asr(p1, 15);
  assign den_c = x1_c + md;
  assign num_c = mc << 11;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      x1_2 <= x1_c;
      an2  <= num_c[31] ? 32'd0 - num_c : num_c;
      ad2  <= den_c[31] ? 32'd0 - den_c : den_c;
      neg2 <= num_c[31] ^ den_c[31];
      dz2  <= (den_c == 32'd0);
      up2  <= up1;
    end
  end

  // ---------------- temperature divider ----------------
  typedef struct packed {
    logic [31:0] x1;
    logic [23:0] up;
    logic        neg;
    logic        dz;
  } tside_t;

  tside_t      tside [DIV_STAGES];
  logic        tdv;
  logic [31:0] tq;

  bsc_div u_tdiv (
    .clk(clk), .rst(rst), .en(en), .in_valid(v2),
    .num(an2), .den(ad2), .out_valid(tdv), .quo(tq)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      tside[0] <= '{x1: x1_2, up: up2, neg: neg2, dz: dz2};
      for (int k = 1; k < DIV_STAGES; k++) tside[k] <= tside[k-1];
    end
  end

  // ---------------- stage 3: B5, temperature, B6 ----------------
  tside_t      ts;
  logic [31:0] x2_c, b5_c, tmp_c;
  assign ts    = tside[DIV_STAGES-1];
  assign x2_c  = ts.dz ? 32'd0 : (ts.neg ? 32'd0 - tq : tq);
  assign b5_c  = ts.x1 + x2_c;
  assign tmp_c = asr(b5_c + 32'd8, 4);

  logic        v3, e3;
  logic [27:0] t3;
  logic [31:0] b6_3;
  logic [23:0] up3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= tdv;
    if (en) begin
      t3   <= ts.dz ? 28'd0 : tmp_c[27:0];
      e3   <= ts.dz;
      b6_3 <= b5_c - 32'd4000;
      up3  <= ts.up;
    end
  end

  // ---------------- stage 4: B6 products ----------------
  logic        v4, e4;
  logic [27:0] t4;
  logic [23:0] up4;
  logic [31:0] m66, m2, m3;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      m66 <= b6_3 * b6_3;
      m2  <= ac2 * b6_3;
      m3  <= ac3 * b6_3;
      t4  <= t3;
      e4  <= e3;
      up4 <= up3;
    end
  end

  // ---------------- stage 5: products with (B6*B6)>>12 ----------------
  logic        v5, e5;
  logic [27:0] t5;
  logic [23:0] up5;
  logic [31:0] mb2, mb1, m2_5, m3_5, sq_c;
  assign sq_c = asr(m66, 12);

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
    if (en) begin
      mb2  <= b2 * sq_c;
      mb1  <= b1 * sq_c;
      m2_5 <= m2;
      m3_5 <= m3;
      t5   <= t4;
      e5   <= e4;
      up5  <= up4;
    end
  end

  // ---------------- stage 6: B3 and X3 for B4 ----------------
  logic        v6, e6;
  logic [27:0] t6;
  logic [23:0] up6;
  logic [31:0] b3_6, x3_6, x3a_c, b3_c;
  assign x3a_c = asr(mb2, 11) + asr(m2_5, 11);
  assign b3_c  = asr(((ac1 * 32'd4 + x3a_c) << oss) + 32'd2, 2);

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
    if (en) begin
      b3_6 <= b3_c;
      x3_6 <= asr(asr(m3_5, 13) + asr(mb1, 16) + 32'd2, 2);
      t6   <= t5;
      e6   <= e5;
      up6  <= up5;
    end
  end

  // ---------------- stage 7: B4 and B7 ----------------
  logic        v7, e7;
  logic [27:0] t7;
  logic [31:0] b4_7, b7_7, b4p_c;
  assign b4p_c = ac4 * (x3_6 + 32'd32768);

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
    if (en) begin
      b4_7 <= b4p_c >> 15;
      b7_7 <= ({8'd0, up6} - b3_6) * (32'd50000 >> oss);
      t7   <= t6;
      e7   <= e6;
    end
  end

  // ---------------- pressure divider ----------------
  typedef struct packed {
    logic [27:0] t;
    logic        e0;
    logic        hi;
    logic        bz;
  } pside_t;

  pside_t      pside [DIV_STAGES];
  logic        pdv;
  logic [31:0] pq, pnum;
  logic        hi7;
  assign hi7  = b7_7[31];
  assign pnum = hi7 ? b7_7 : (b7_7 << 1);

  bsc_div u_pdiv (
    .clk(clk), .rst(rst), .en(en), .in_valid(v7),
    .num(pnum), .den(b4_7), .out_valid(pdv), .quo(pq)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      pside[0] <= '{t: t7, e0: e7, hi: hi7, bz: (b4_7 == 32'd0)};
      for (int k = 1; k < DIV_STAGES; k++) pside[k] <= pside[k-1];
    end
  end

  // ---------------- stage 8: raw pressure and correction products ----------
  pside_t      ps;
  logic [31:0] pr_c, px_c;
  assign ps   = pside[DIV_STAGES-1];
  assign pr_c = ps.hi ? (pq << 1) : pq;
  assign px_c = asr(pr_c, 8);

  logic        v8;
  pside_t      ps8;
  logic [31:0] p8, mx8, my8;

  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= pdv;
    if (en) begin
      p8  <= pr_c;
      mx8 <= px_c * px_c;
      my8 <= (32'd0 - 32'd7357) * pr_c;
      ps8 <= ps;
    end
  end

  // ---------------- stage 9: scaled correction terms ----------------
  logic        v9;
  pside_t      ps9;
  logic [31:0] p9, cx9, cy9, mx3038_c;
  assign mx3038_c = mx8 * 32'd3038;

  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (en) v9 <= v8;
    if (en) begin
      p9  <= p8;
      cx9 <= asr(mx3038_c, 16);
      cy9 <= asr(my8, 16);
      ps9 <= ps8;
    end
  end

  // ---------------- output register ----------------
  logic [31:0] pf_c;
  assign pf_c = p9 + asr(cx9 + cy9 + 32'd3791, 4);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v9;
    if (en) begin
      temperature_tenths <= ps9.t;
      pressure_pa        <= ps9.bz ? 32'sd0 : pf_c;
      divide_error       <= {ps9.bz, ps9.e0};
    end
  end

  // ---------------- assertions ----------------
  a_terr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_error[0] |-> temperature_tenths == 28'sd0)
    else $error("temperature not zeroed on divide error");

  a_perr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_error[1] |-> pressure_pa == 32'sd0)
    else $error("pressure not zeroed on divide error");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

endmodule

// ----- tb/sv/bsc_checker.sv -----
// ----------------------------------------------------------------------------
// bsc_checker: compensation predictor and result scoreboard
// Watches both channels, computes expected temperature/pressure per accepted
// input transaction, and compares each output transaction in order.
// ----------------------------------------------------------------------------
module bsc_checker
  import bsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [15:0]        raw_temperature,
  input  logic [23:0]        raw_pressure_bytes,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [27:0] temperature_tenths,
  input  logic signed [31:0] pressure_pa,
  input  logic [1:0]         divide_error,
  output int                 fail_count,
  output int                 pending
);

  typedef struct {
    logic [27:0] temp;
    logic [31:0] pres;
    logic [1:0]  err;
  } comp_result_t;

  logic [63:0] coef_a, coef_b;
  logic [31:0] coef_c;
  logic [1:0]  oss;
  comp_result_t expected_q[$];

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] ashr(input logic [31:0] v, input int n);
    return $unsigned($signed(v) >>> n);
  endfunction

  function automatic comp_result_t compensate(input logic [15:0] ut_raw,
                                              input logic [23:0] up_raw);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p, q, an, ad;
    comp_result_t r;
    ac1 = sext16(coef_a[15:0]);  ac2 = sext16(coef_a[31:16]);
    ac3 = sext16(coef_a[47:32]); ac4 = {16'd0, coef_a[63:48]};
    ac5 = {16'd0, coef_b[15:0]}; ac6 = {16'd0, coef_b[31:16]};
    b1  = sext16(coef_b[47:32]); b2  = sext16(coef_b[63:48]);
    mc  = sext16(coef_c[15:0]);  md  = sext16(coef_c[31:16]);
    ut = {16'd0, ut_raw};
    up = {8'd0, up_raw} >> (8 - oss);
    r.err = 2'b00;
    // temperature
    x1 = ashr((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) begin
      r.err[0] = 1'b1;
      x2 = 0;
    end else begin
      // signed divide, truncating toward zero
      an = mc[31] ? -(mc << 11) : (mc << 11);
      ad = den[31] ? -den : den;
      q = an / ad;
      x2 = (mc[31] != den[31]) ? -q : q;
    end
    b5 = x1 + x2;
    r.temp = r.err[0] ? 28'd0 : 28'(ashr(b5 + 32'd8, 4));
    // pressure
    b6 = b5 - 32'd4000;
    sq = ashr(b6 * b6, 12);
    x3 = ashr(b2 * sq, 11) + ashr(ac2 * b6, 11);
    b3 = ashr(((ac1 * 4 + x3) << oss) + 32'd2, 2);
    x1 = ashr(ac3 * b6, 13);
    x2 = ashr(b1 * sq, 16);
    x3 = ashr(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + 32'd32768)) >> 15;
    b7 = (up - b3) * (32'd50000 >> oss);
    if (b4 == 0) begin
      r.err[1] = 1'b1;
      p = 0;
    end else begin
      p = (b7 < 32'h8000_0000) ? (b7 << 1) / b4 : (b7 / b4) << 1;
      x1 = ashr(p, 8);
      x1 = x1 * x1;
      x1 = ashr(x1 * 32'd3038, 16);
      x2 = ashr((32'd0 - 32'd7357) * p, 16);
      p = p + ashr(x1 + x2 + 32'd3791, 4);
    end
    r.pres = p;
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    comp_result_t e;
    if (rst) begin
      coef_a <= '0; coef_b <= '0; coef_c <= '0; oss <= 2'd3;
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (in_valid && in_ready)
        expected_q.push_back(compensate(raw_temperature, raw_pressure_bytes));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (temperature_tenths !== e.temp) begin
            $error("temperature_tenths exp %0d got %0d", $signed(e.temp),
                   temperature_tenths);
            fail_count <= fail_count + 1;
          end
          if (pressure_pa !== e.pres) begin
            $error("pressure_pa exp %0d got %0d", $signed(e.pres), pressure_pa);
            fail_count <= fail_count + 1;
          end
          if (divide_error !== e.err) begin
            $error("divide_error exp %0d got %0d", e.err, divide_error);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_COEF_A:       coef_a <= cfg_data;
          REG_COEF_B:       coef_b <= cfg_data;
          REG_COEF_C:       coef_c <= cfg_data[31:0];
          REG_OVERSAMPLING: oss <= cfg_data[1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- tb/sv/tb_barometric_sensor_compensation_core.sv -----
// ----------------------------------------------------------------------------
// tb_barometric_sensor_compensation_core: stimulus and verdict
// Drives calibration sets and raw readings through the compensation core
// under varying flow-control pressure; bsc_checker scores every result.
// ----------------------------------------------------------------------------
module tb_barometric_sensor_compensation_core;
  import bsc_pkg::*;

  localparam int LATENCY   = 74;
  localparam int MAX_CYCLE = 400000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [63:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [15:0]        raw_temperature = '0;
  logic [23:0]        raw_pressure_bytes = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [27:0] temperature_tenths;
  logic signed [31:0] pressure_pa;
  logic [1:0]         divide_error;
  int                 fail_count, pending;
  int                 cycle = 0;
  int                 send_idle_pct = 0;   // sender idle chance, percent
  int                 recv_stall_pct = 0;  // receiver stall chance, percent

  always #10 clk = ~clk;

  barometric_sensor_compensation_core dut (.*);
  bsc_checker u_checker (.*);

  // cycle watchdog
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= MAX_CYCLE) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stalls, updated on the falling edge
  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // one register write, one cycle wide
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // present one reading and hold it until the transaction completes;
  // valid stays up afterwards so readings can go back to back
  task automatic send_reading(input logic [15:0] ut, input logic [23:0] up);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    raw_temperature    <= ut;
    raw_pressure_bytes <= up;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // drop valid, wait for all results, then let the pipe drain
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // realistic datasheet-like calibration, randomly perturbed
  task automatic load_typical_cal();
    write_reg(REG_COEF_A, {16'd32741 + 16'($urandom_range(1000)), 16'hC790,
                           16'hFB8C, 16'd408 + 16'($urandom_range(500))});
    write_reg(REG_COEF_B, {16'h0004, 16'd6190, 16'd23153,
                           16'd32757 - 16'($urandom_range(3000))});
    write_reg(REG_COEF_C, 64'({16'd2868, 16'hD4BD + 16'($urandom_range(200))}));
  endtask

  task automatic load_random_cal();
    write_reg(REG_COEF_A, {$urandom, $urandom});
    write_reg(REG_COEF_B, {$urandom, $urandom});
    write_reg(REG_COEF_C, {32'h0, $urandom});
  endtask

  initial begin
    int phase;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset calibration makes both divisors zero
    send_reading(16'h0000, 24'h000000);
    send_reading(16'hFFFF, 24'hFFFFFF);
    drain();
    // temperature divisor zero: ac5 = 0 gives x1 = 0, md = 0
    write_reg(REG_COEF_A, {16'd32741, 16'hC790, 16'hFB8C, 16'd408});
    write_reg(REG_COEF_B, {16'd32757, 16'h0004, 16'd23153, 16'd0});
    write_reg(REG_COEF_C, 64'h0);
    send_reading(16'd27898, 24'h9D1E00);
    drain();
    // field extremes across every oversampling setting
    load_typical_cal();
    for (int o = 0; o < 4; o++) begin
      write_reg(REG_OVERSAMPLING, 64'(o));
      send_reading(16'h0000, 24'h000000);
      send_reading(16'hFFFF, 24'hFFFFFF);
      send_reading(16'h5555, 24'hAAAAAA);
      send_reading(16'hAAAA, 24'h555555);
      drain();
    end
    // extreme coefficient words for wraparound in wide intermediates
    write_reg(REG_COEF_A, 64'hFFFF_8000_7FFF_8000);
    write_reg(REG_COEF_B, 64'h8000_7FFF_FFFF_FFFF);
    write_reg(REG_COEF_C, 64'h7FFF_8000);
    send_reading(16'hFFFF, 24'hFFFFFF);
    send_reading(16'h0001, 24'h800000);
    drain();

    // random part: four pressure phases, mostly realistic calibration
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      for (int s = 0; s < 5; s++) begin
        if (s == 4) load_random_cal();
        else load_typical_cal();
        write_reg(REG_OVERSAMPLING, 64'($urandom_range(3)));
        for (int k = 0; k < 20; k++)
          if ($urandom_range(3) == 0)
            send_reading(16'($urandom), 24'($urandom));
          else
            send_reading(16'd20000 + 16'($urandom_range(15000)),
                         24'h800000 + 24'($urandom_range(24'h3FFFFF)));
        drain();
      end
    end

    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/bsc_pkg.sv
hdl/bsc_div.sv
hdl/barometric_sensor_compensation_core.sv
tb/sv/bsc_checker.sv
tb/sv/tb_barometric_sensor_compensation_core.sv
